FILE: hdl/assert_macros.svh
// Assertion helpers shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tpt_pkg.sv
`default_nettype none
package tpt_pkg;

    // Field widths
    localparam int FIELD_W         = 16;
    localparam int SCALE_W         = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int WIN_W           = 32;
    localparam int REG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int LEFT_HOLD_W     = 24;
    localparam int RIGHT_HOLD_W    = 8;

    // Hold times in polls
    localparam logic [RIGHT_HOLD_W-1:0] TAP_HOLD_TICKS  = 8'd10;
    localparam logic [LEFT_HOLD_W-1:0]  LONG_HOLD_TICKS = 24'd10000000;

    // Register reset values
    localparam logic [WIN_W-1:0]   RST_CLIP_WINDOW_X = 32'd31391744;
    localparam logic [WIN_W-1:0]   RST_CLIP_WINDOW_Y = 32'd20905984;
    localparam logic [SCALE_W-1:0] RST_SCALE         = 16'd256;
    localparam logic [WIN_W-1:0]   RST_LIMIT_X       = 32'd20971520;
    localparam logic [WIN_W-1:0]   RST_LIMIT_Y       = 32'd13107200;

    typedef enum logic {
        FUNC_POLL = 1'b0,
        FUNC_SET  = 1'b1
    } tpt_func_t;

    typedef enum logic [1:0] {
        CLICK_NONE  = 2'd0,
        CLICK_LEFT  = 2'd1,
        CLICK_RIGHT = 2'd2,
        CLICK_LONG  = 2'd3
    } tpt_click_t;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_LEFT  = 2'd1,
        BTN_RIGHT = 2'd2
    } tpt_button_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RELATIVE_MODE = 3'd0,
        REG_CLIP_WINDOW_X = 3'd1,
        REG_CLIP_WINDOW_Y = 3'd2,
        REG_SCALE_X       = 3'd3,
        REG_SCALE_Y       = 3'd4,
        REG_LIMIT_X       = 3'd5,
        REG_LIMIT_Y       = 3'd6
    } tpt_reg_t;

    typedef struct packed {
        logic                       func;
        logic signed [FIELD_W-1:0]  coord_x;
        logic signed [FIELD_W-1:0]  coord_y;
        logic [1:0]                 click;
    } tpt_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  pointer_x;
        logic signed [FIELD_W-1:0]  pointer_y;
        logic [1:0]                 buttons;
    } tpt_out_t;

    // Per-axis settings: window and limit pack low edge in [15:0], high in [31:16]
    typedef struct packed {
        logic [WIN_W-1:0]   clip;
        logic [SCALE_W-1:0] scale;
        logic [WIN_W-1:0]   limit;
    } tpt_axis_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/tpt_axis.sv
`default_nettype none
// One pointer axis: window clamp, Q8.8 scale, limit clamp and the stored position.
module tpt_axis #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  commit,
    input  wire logic                                  relative,
    input  wire logic                                  set_pos,
    input  wire tpt_pkg::tpt_axis_cfg_t                cfg,
    input  wire logic signed [tpt_pkg::FIELD_W-1:0]    coord,
    output logic signed [tpt_pkg::FIELD_W-1:0]         pointer_next
);

    localparam int FW       = tpt_pkg::FIELD_W;
    localparam int FRAC     = tpt_pkg::SCALE_FRAC_BITS;
    localparam int MUL_W    = FW + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SCALED_W = PROD_W - FRAC;
    localparam int SUM_W    = ((SCALED_W > COORD_BITS) ? SCALED_W : COORD_BITS) + 1;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC) - 1);

    logic signed [FW-1:0]         win_lo;
    logic signed [FW-1:0]         win_hi;
    logic signed [FW-1:0]         lim_lo;
    logic signed [FW-1:0]         lim_hi;
    logic signed [FW-1:0]         win_clamp;
    logic signed [MUL_W-1:0]      offset;
    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     prod_adj;
    logic signed [SCALED_W-1:0]   scaled;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      lim_clamp;
    logic signed [FW-1:0]         clamp_res;
    logic signed [COORD_BITS-1:0] pos_reg;
    logic signed [COORD_BITS-1:0] pos_next;

    // Clamp to clip window (lower edge first, upper edge wins), then offset
    always_comb
    begin
        win_lo = cfg.clip[FW-1:0];
        win_hi = cfg.clip[2*FW-1:FW];
        lim_lo = cfg.limit[FW-1:0];
        lim_hi = cfg.limit[2*FW-1:FW];

        win_clamp = coord;
        if (coord < win_lo)
        begin
            win_clamp = win_lo;
        end
        if (win_clamp > win_hi)
        begin
            win_clamp = win_hi;
        end
        offset = MUL_W'(win_clamp) - MUL_W'(win_lo);
    end

    // Q8.8 scale, truncating toward zero
    always_comb
    begin
        mul_a    = relative ? MUL_W'(coord) : offset;
        mul_b    = {1'b0, cfg.scale};
        prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_adj = prod[PROD_W-1] ? (prod + TRUNC_BIAS) : prod;
        scaled   = prod_adj[PROD_W-1:FRAC];
    end

    // Accumulate in relative mode, clamp to limits (maximum wins)
    always_comb
    begin
        sum = relative ? (SUM_W'(scaled) + SUM_W'(pos_reg)) : SUM_W'(scaled);
        lim_clamp = sum;
        if (sum < SUM_W'(lim_lo))
        begin
            lim_clamp = SUM_W'(lim_lo);
        end
        if (lim_clamp > SUM_W'(lim_hi))
        begin
            lim_clamp = SUM_W'(lim_hi);
        end
        clamp_res = lim_clamp[FW-1:0];

        // set position stores the raw coordinate
        pos_next     = set_pos ? COORD_BITS'(coord) : COORD_BITS'(clamp_res);
        pointer_next = FW'(pos_next);
    end

    // Stored position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (commit)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tpt_hold.sv
`default_nettype none
`include "assert_macros.svh"
// Button hold counters and the reported button state.
module tpt_hold (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       commit,
    input  wire logic       poll,
    input  wire logic [1:0] click,
    output logic [1:0]      buttons_next
);

    localparam int LW = tpt_pkg::LEFT_HOLD_W;
    localparam int RW = tpt_pkg::RIGHT_HOLD_W;

    logic [LW-1:0]        left_hold_reg;
    logic [LW-1:0]        left_hold_next;
    logic [LW-1:0]        left_load;
    logic [RW-1:0]        right_hold_reg;
    logic [RW-1:0]        right_hold_next;
    logic [RW-1:0]        right_load;
    tpt_pkg::tpt_button_t button_state_reg;
    tpt_pkg::tpt_button_t button_state_next;

    // Load counters from the click code
    always_comb
    begin
        left_load  = left_hold_reg;
        right_load = right_hold_reg;
        case (click)
            tpt_pkg::CLICK_LEFT:  left_load  = LW'(tpt_pkg::TAP_HOLD_TICKS);
            tpt_pkg::CLICK_RIGHT: right_load = tpt_pkg::TAP_HOLD_TICKS;
            tpt_pkg::CLICK_LONG:  left_load  = tpt_pkg::LONG_HOLD_TICKS;
            default:              ;
        endcase
    end

    // Count down once per poll; set-position items leave everything as is
    always_comb
    begin
        left_hold_next    = left_hold_reg;
        right_hold_next   = right_hold_reg;
        button_state_next = button_state_reg;
        if (poll)
        begin
            left_hold_next  = (left_load != '0) ? (left_load - LW'(1)) : '0;
            right_hold_next = (right_load != '0) ? (right_load - RW'(1)) : '0;
            if (left_hold_next != '0)
            begin
                button_state_next = tpt_pkg::BTN_LEFT;
            end
            else if (right_hold_next != '0)
            begin
                button_state_next = tpt_pkg::BTN_RIGHT;
            end
            else
            begin
                button_state_next = tpt_pkg::BTN_NONE;
            end
        end
        buttons_next = button_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_hold_reg    <= '0;
            right_hold_reg   <= '0;
            button_state_reg <= tpt_pkg::BTN_NONE;
        end
        else if (commit)
        begin
            left_hold_reg    <= left_hold_next;
            right_hold_reg   <= right_hold_next;
            button_state_reg <= button_state_next;
        end
    end

    // Reported state agrees with the counters
    `ASSERT_SAME(a_none_idle, clk, rst_n, button_state_reg == tpt_pkg::BTN_NONE, left_hold_reg == '0 && right_hold_reg == '0, "button none with a live counter")
    `ASSERT_SAME(a_right_only, clk, rst_n, button_state_reg == tpt_pkg::BTN_RIGHT, left_hold_reg == '0 && right_hold_reg != '0, "right reported while left held or right expired")

endmodule
`default_nettype wire

FILE: hdl/touch_pointer_tracker.sv
`default_nettype none
`include "assert_macros.svh"
// Touch pointer tracker.
// Input channel (in_valid/in_ready/in_item): one item per poll or set-position
// command. Output channel (out_valid/out_ready/out_item): exactly one result
// item per input item, in order, carrying pointer x/y and the button state.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// registers only while no item is in flight.
// Each accepted item is held in the input register and moves into the result
// register once the result slot is free; out_valid rises when it lands there.
// Throughput: one item per cycle while the receiver takes each result; the
// window clamp, one 17x17 multiply per axis, limit clamp and counter update
// all sit between the input register and the result register.
// Reset clears the pointer to 0, both hold counters and the button state, and
// loads the register defaults. When the receiver stalls, the result register
// holds; the input register still takes one more item, after which in_ready
// drops until the result is taken.
module touch_pointer_tracker #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire tpt_pkg::tpt_in_t                      in_item,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output tpt_pkg::tpt_out_t                          out_item,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tpt_pkg::REG_IDX_W-1:0]         cfg_index,
    input  wire logic [tpt_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int FW = tpt_pkg::FIELD_W;
    localparam int SW = tpt_pkg::SCALE_W;
    localparam int WW = tpt_pkg::WIN_W;

    logic                   relative_mode_reg;
    logic [WW-1:0]          clip_window_x_reg;
    logic [WW-1:0]          clip_window_y_reg;
    logic [SW-1:0]          scale_x_reg;
    logic [SW-1:0]          scale_y_reg;
    logic [WW-1:0]          limit_x_reg;
    logic [WW-1:0]          limit_y_reg;

    logic                   in_valid_reg;
    tpt_pkg::tpt_in_t       in_item_reg;
    logic                   out_valid_reg;
    tpt_pkg::tpt_out_t      out_item_reg;

    logic                   advance;
    logic                   set_pos;
    logic                   poll;
    tpt_pkg::tpt_axis_cfg_t cfg_x;
    tpt_pkg::tpt_axis_cfg_t cfg_y;
    logic signed [FW-1:0]   pointer_x_next;
    logic signed [FW-1:0]   pointer_y_next;
    logic [1:0]             buttons_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relative_mode_reg <= 1'b0;
            clip_window_x_reg <= tpt_pkg::RST_CLIP_WINDOW_X;
            clip_window_y_reg <= tpt_pkg::RST_CLIP_WINDOW_Y;
            scale_x_reg       <= tpt_pkg::RST_SCALE;
            scale_y_reg       <= tpt_pkg::RST_SCALE;
            limit_x_reg       <= tpt_pkg::RST_LIMIT_X;
            limit_y_reg       <= tpt_pkg::RST_LIMIT_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpt_pkg::REG_RELATIVE_MODE: relative_mode_reg <= cfg_data[0];
                tpt_pkg::REG_CLIP_WINDOW_X: clip_window_x_reg <= cfg_data;
                tpt_pkg::REG_CLIP_WINDOW_Y: clip_window_y_reg <= cfg_data;
                tpt_pkg::REG_SCALE_X:       scale_x_reg       <= cfg_data[SW-1:0];
                tpt_pkg::REG_SCALE_Y:       scale_y_reg       <= cfg_data[SW-1:0];
                tpt_pkg::REG_LIMIT_X:       limit_x_reg       <= cfg_data;
                tpt_pkg::REG_LIMIT_Y:       limit_y_reg       <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Handshake: the item in the input register moves on when the result slot frees
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    // Per-axis datapath
    assign set_pos = (in_item_reg.func == tpt_pkg::FUNC_SET);
    assign poll    = !set_pos;
    assign cfg_x   = '{clip: clip_window_x_reg, scale: scale_x_reg, limit: limit_x_reg};
    assign cfg_y   = '{clip: clip_window_y_reg, scale: scale_y_reg, limit: limit_y_reg};

    tpt_axis #(
        .COORD_BITS(COORD_BITS)
    ) u_axis_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (advance),
        .relative     (relative_mode_reg),
        .set_pos      (set_pos),
        .cfg          (cfg_x),
        .coord        (in_item_reg.coord_x),
        .pointer_next (pointer_x_next)
    );

    tpt_axis #(
        .COORD_BITS(COORD_BITS)
    ) u_axis_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (advance),
        .relative     (relative_mode_reg),
        .set_pos      (set_pos),
        .cfg          (cfg_y),
        .coord        (in_item_reg.coord_y),
        .pointer_next (pointer_y_next)
    );

    tpt_hold u_hold (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (advance),
        .poll         (poll),
        .click        (in_item_reg.click),
        .buttons_next (buttons_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.pointer_x <= pointer_x_next;
            out_item_reg.pointer_y <= pointer_y_next;
            out_item_reg.buttons   <= buttons_next;
        end
    end

    // Pipeline bookkeeping
    `ASSERT_SAME(a_no_overrun, clk, rst_n, in_valid_reg && out_valid_reg && !out_ready, !in_ready, "input register would be overwritten")
    `ASSERT_NEXT(a_result_lands, clk, rst_n, advance, out_valid_reg, "advanced item produced no result")

endmodule
`default_nettype wire
